>>> design/srpg_pkg.sv
// Package for the stepper ramp pulse generator.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none
package srpg_pkg;

  localparam int IVAL_W = 32;
  localparam int OFFS_W = 20;
  localparam int TRIG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int STEP_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [IVAL_W-1:0] START_INTERVAL_RST = 32'd313262080;
  localparam logic [OFFS_W-1:0] INTERVAL_OFFSET_RST = 20'd245760;
  localparam logic [TRIG_W-1:0] TRIGGER_PERIOD_RST = 16'd160;
  localparam logic [TRIG_W-1:0] TRIGGER_WIDTH_RST = 16'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 2'd3;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } srpg_state_t;

endpackage
`default_nettype wire

>>> design/stepper_ramp_pulse_generator.sv
// Stepper ramp pulse generator top level: step timing, position, home switch and trigger.
// Depends on srpg_pkg.
`default_nettype none
// Each input word is a one microsecond tick or a start command and gives exactly one
// output word, registered. A new input is taken only when the output register is empty
// or its word is taken in the same cycle.
// An input word that fires a step on either ramp starts an interval update
// c = |c - 2c/(4n+1)|, done by a bit-serial restoring divider that produces one
// quotient bit per cycle, followed by a finish state that forms and saturates
// the new interval. No input is taken until the update is done; after any other
// word, only the output register can hold back the next input.
module stepper_ramp_pulse_generator #(
  parameter int STEP_BITS = srpg_pkg::STEP_BITS_DEF,
  parameter int FRAC_BITS = srpg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_func,
  input  wire logic [STEP_BITS-1:0]           in_move_steps,
  input  wire logic                           in_move_up,
  input  wire logic [STEP_BITS-1:0]           in_ramp_steps,
  input  wire logic                           in_home_switch,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_step_pulse,
  output logic                                out_dir_out,
  output logic                                out_trigger_level,
  output logic signed [srpg_pkg::IVAL_W-1:0]  out_position,
  output logic                                out_busy_res,
  output logic                                out_pos_reached,
  output logic                                out_limit_hit,
  output logic                                out_homed,
  input  wire logic                           cfg_we,
  input  wire logic [srpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srpg_pkg::IVAL_W-1:0]    cfg_wdata
);
  import srpg_pkg::*;

  localparam int SB = STEP_BITS;
  localparam int DVD_W = IVAL_W + 1;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int DM_W = SB + 2;
  localparam int RM_W = SB + 3;

  logic [IVAL_W-1:0] cfg_start_r;
  logic [OFFS_W-1:0] cfg_offset_r;
  logic [TRIG_W-1:0] cfg_period_r;
  logic [TRIG_W-1:0] cfg_width_r;

  logic [IVAL_W-1:0] pos_r, pos_nxt;
  logic [SB-1:0] left_r, left_nxt;
  logic [SB-1:0] idx_r, idx_nxt;
  logic [SB-1:0] total_r, total_nxt;
  logic [SB-1:0] ramp_r, ramp_nxt;
  logic [IVAL_W-1:0] ival_r, ival_nxt;
  logic [IVAL_W-1:0] wait_r, wait_nxt;
  logic [TRIG_W-1:0] phase_r, phase_nxt;
  logic up_r, up_nxt;
  logic run_r, run_nxt;
  logic homed_r, homed_nxt;
  logic trig_r, trig_nxt;

  logic out_valid_r;
  logic out_pulse_r, out_reached_r, out_limit_r;
  logic o_pulse, o_reached, o_limit;

  srpg_state_t state_r, state_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [RM_W-1:0] rem_r;
  logic [DM_W-1:0] dmag_r, dmag_nxt;
  logic dneg_r, dneg_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic div_start;
  logic in_fire;
  logic div_active, div_fin;

  logic [RM_W-1:0] trial;
  logic trial_ge;
  logic [IVAL_W+1:0] fin_sum;
  logic [IVAL_W-1:0] fin_ival;

  assign in_fire = in_valid && in_ready;

  always_comb begin : accept_logic
    logic [SB-1:0] b_left, b_idx, b_total, b_ramp, f_left;
    logic [IVAL_W-1:0] b_ival;
    logic [TRIG_W-1:0] b_phase, per;
    logic b_up, do_fire, t;
    logic signed [IVAL_W:0] diff;
    logic [IVAL_W:0] mag;
    logic [IVAL_W+1:0] rnd;
    logic [SB:0] s;
    logic [RM_W-1:0] d;
    b_left = left_r;
    b_idx = idx_r;
    b_total = total_r;
    b_ramp = ramp_r;
    b_ival = ival_r;
    b_phase = phase_r;
    b_up = up_r;
    do_fire = 1'b0;
    s = '0;
    t = trig_r;
    per = cfg_period_r;
    pos_nxt = pos_r;
    wait_nxt = wait_r;
    run_nxt = run_r;
    homed_nxt = homed_r;
    trig_nxt = trig_r;
    o_pulse = 1'b0;
    o_reached = 1'b0;
    o_limit = 1'b0;
    div_start = 1'b0;
    if (in_func == FUNC_START) begin
      if (in_move_steps != '0) begin
        b_left = in_move_steps;
        b_idx = '0;
        b_total = in_move_steps;
        b_ramp = in_ramp_steps;
        b_ival = cfg_start_r;
        b_phase = '0;
        b_up = in_move_up;
        run_nxt = 1'b1;
        wait_nxt = '0;
        do_fire = 1'b1;
      end
    end else if (run_r) begin
      if (wait_r <= IVAL_W'(1)) begin
        do_fire = 1'b1;
      end else begin
        wait_nxt = wait_r - IVAL_W'(1);
      end
    end
    left_nxt = b_left;
    idx_nxt = b_idx;
    total_nxt = b_total;
    ramp_nxt = b_ramp;
    ival_nxt = b_ival;
    phase_nxt = b_phase;
    up_nxt = b_up;

    diff = $signed({1'b0, b_ival}) - $signed({{(IVAL_W + 1 - OFFS_W){1'b0}}, cfg_offset_r});
    mag = diff[IVAL_W] ? (~diff + 1'b1) : diff;
    rnd = {1'b0, mag} + ((IVAL_W + 2)'(1) << (FRAC_BITS - 1));
    f_left = b_left - SB'(1);

    if (do_fire) begin
      left_nxt = f_left;
      if (f_left != '0) begin
        wait_nxt = IVAL_W'(rnd >> FRAC_BITS);
      end else begin
        o_reached = 1'b1;
        run_nxt = 1'b0;
      end
      if (b_up && in_home_switch) begin
        left_nxt = '0;
        pos_nxt = '0;
        homed_nxt = 1'b1;
        o_limit = 1'b1;
        run_nxt = 1'b0;
      end else begin
        pos_nxt = b_up ? pos_r + IVAL_W'(1) : pos_r - IVAL_W'(1);
        o_pulse = 1'b1;
        if (b_idx <= b_ramp) begin
          div_start = 1'b1;
          s = {1'b0, b_idx};
        end else if (({1'b0, b_idx} + {1'b0, b_ramp}) >= {1'b0, b_total}) begin
          div_start = 1'b1;
          s = {1'b0, b_idx} - {1'b0, b_total};
        end
        if (b_phase == '0) begin
          t = 1'b1;
        end
        if (b_phase == cfg_width_r) begin
          t = 1'b0;
        end
        trig_nxt = t;
        if (cfg_period_r == '0) begin
          per = TRIG_W'(1);
        end
        phase_nxt = (({1'b0, b_phase} + (TRIG_W + 1)'(1)) >= {1'b0, per}) ?
                    '0 : b_phase + TRIG_W'(1);
        idx_nxt = b_idx + SB'(1);
      end
    end

    d = {s, 2'b01};
    dneg_nxt = d[RM_W-1];
    dmag_nxt = dneg_nxt ? DM_W'(~d + 1'b1) : DM_W'(d);
    dvd_nxt = {b_ival, 1'b0};
  end

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin : state_outputs
    in_ready = 1'b0;
    div_active = 1'b0;
    div_fin = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      ST_DIV: begin
        div_active = 1'b1;
      end
      ST_FIN: begin
        div_fin = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign trial = {rem_r[RM_W-2:0], dvd_r[DVD_W-1]};
  assign trial_ge = trial >= {1'b0, dmag_r};

  always_comb begin : finish_logic
    logic [IVAL_W+1:0] c_ext, q_ext;
    c_ext = {2'b00, ival_r};
    q_ext = {1'b0, dvd_r};
    if (dneg_r) begin
      fin_sum = c_ext + q_ext;
    end else if (q_ext > c_ext) begin
      fin_sum = q_ext - c_ext;
    end else begin
      fin_sum = c_ext - q_ext;
    end
    fin_ival = (fin_sum[IVAL_W+1:IVAL_W] != 2'b00) ? '1 : fin_sum[IVAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r <= START_INTERVAL_RST;
      cfg_offset_r <= INTERVAL_OFFSET_RST;
      cfg_period_r <= TRIGGER_PERIOD_RST;
      cfg_width_r <= TRIGGER_WIDTH_RST;
      pos_r <= '0;
      left_r <= '0;
      idx_r <= '0;
      total_r <= '0;
      ramp_r <= '0;
      ival_r <= '0;
      wait_r <= '0;
      phase_r <= '0;
      up_r <= 1'b0;
      run_r <= 1'b0;
      homed_r <= 1'b0;
      trig_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_pulse_r <= 1'b0;
      out_reached_r <= 1'b0;
      out_limit_r <= 1'b0;
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_INTERVAL: cfg_start_r <= cfg_wdata;
          CFG_INTERVAL_OFFSET: cfg_offset_r <= cfg_wdata[OFFS_W-1:0];
          CFG_TRIGGER_PERIOD: cfg_period_r <= cfg_wdata[TRIG_W-1:0];
          CFG_TRIGGER_WIDTH: cfg_width_r <= cfg_wdata[TRIG_W-1:0];
          default: cfg_start_r <= cfg_start_r;
        endcase
      end
      if (in_fire) begin
        pos_r <= pos_nxt;
        left_r <= left_nxt;
        idx_r <= idx_nxt;
        total_r <= total_nxt;
        ramp_r <= ramp_nxt;
        ival_r <= ival_nxt;
        wait_r <= wait_nxt;
        phase_r <= phase_nxt;
        up_r <= up_nxt;
        run_r <= run_nxt;
        homed_r <= homed_nxt;
        trig_r <= trig_nxt;
        out_valid_r <= 1'b1;
        out_pulse_r <= o_pulse;
        out_reached_r <= o_reached;
        out_limit_r <= o_limit;
        dvd_r <= dvd_nxt;
        dmag_r <= dmag_nxt;
        dneg_r <= dneg_nxt;
        rem_r <= '0;
        cnt_r <= '0;
      end else begin
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        if (div_active) begin
          rem_r <= trial_ge ? trial - {1'b0, dmag_r} : trial;
          dvd_r <= {dvd_r[DVD_W-2:0], trial_ge};
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (div_fin) begin
          ival_r <= fin_ival;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_step_pulse = out_pulse_r;
  assign out_dir_out = up_r;
  assign out_trigger_level = trig_r;
  assign out_position = $signed(pos_r);
  assign out_busy_res = run_r;
  assign out_pos_reached = out_reached_r;
  assign out_limit_hit = out_limit_r;
  assign out_homed = homed_r;

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("input taken during interval update");

  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r) else $error("accepted word gave no result");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_W'(DVD_W - 1)) |=> (state_r == ST_FIN))
    else $error("divider did not finish after the last quotient bit");

  a_homed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    homed_r |=> homed_r) else $error("homed flag cleared");

  a_limit_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && o_limit) |=> (pos_r == '0 && !run_r))
    else $error("home stop left position or run state wrong");

endmodule
`default_nettype wire
